@@ rtl/pwfd_pkg.sv @@
// Shared types and constants for the pulse-width frame decoder.
// Used by pwfd_frame_core and pulse_width_frame_decoder_unit.
package pwfd_pkg;

    // Frame storage: bit i of a frame lives at bit (FRAME_WORD-1-i).
    localparam int FRAME_WORD         = 64;
    localparam int FRAME_POS_W        = $clog2(FRAME_WORD);
    localparam int FRAME_BITS_DEFAULT = 40;
    localparam int FRAME_BITS_MIN     = 8;
    localparam int FRAME_BITS_MAX     = 64;

    localparam int TIME_W   = 16;
    localparam int KIND_W   = 2;
    localparam int CFG_IDX_W = 3;

    localparam logic [KIND_W-1:0] KIND_START  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EDGE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FINISH = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_START_MIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_MAX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_MIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_MAX  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_MIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_MAX   = 3'd5;

    localparam logic [TIME_W-1:0] START_MIN_RST = 16'd120;
    localparam logic [TIME_W-1:0] START_MAX_RST = 16'd200;
    localparam logic [TIME_W-1:0] ZERO_MIN_RST  = 16'd70;
    localparam logic [TIME_W-1:0] ZERO_MAX_RST  = 16'd100;
    localparam logic [TIME_W-1:0] ONE_MIN_RST   = 16'd110;
    localparam logic [TIME_W-1:0] ONE_MAX_RST   = 16'd150;

    typedef struct packed {
        logic [TIME_W-1:0] start_min;
        logic [TIME_W-1:0] start_max;
        logic [TIME_W-1:0] zero_min;
        logic [TIME_W-1:0] zero_max;
        logic [TIME_W-1:0] one_min;
        logic [TIME_W-1:0] one_max;
    } pwfd_cfg_t;

    typedef struct packed {
        logic [15:0]        humidity;
        logic signed [15:0] temperature;
        logic [7:0]         checksum;
        logic               frame_ok;
    } pwfd_result_t;

endpackage

@@ rtl/pwfd_frame_core.sv @@
// Frame state and bit decoding for the pulse-width frame decoder.
// Depends on pwfd_pkg; result fields are formed from the current frame state.
module pwfd_frame_core
    import pwfd_pkg::*;
#(
    parameter int FRAME_BITS = FRAME_BITS_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [KIND_W-1:0]   kind,
    input  logic [TIME_W-1:0]   capture_time,
    input  pwfd_cfg_t           cfg,
    output pwfd_result_t        result
);

    localparam int CNT_W = $clog2(FRAME_BITS + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FRAME_BITS);

    logic [TIME_W-1:0]     prev_time_reg, prev_time_next;
    logic                  armed_reg, armed_next;
    logic                  overflow_reg, overflow_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [FRAME_WORD-1:0] frame_reg, frame_next;

    logic [TIME_W-1:0]      dt;
    logic                   in_start, in_zero, in_one;
    logic [FRAME_POS_W-1:0] bit_pos;
    logic [15:0]            magnitude;
    logic [7:0]             byte2;

    assign dt       = capture_time - prev_time_reg;
    assign in_start = (dt >= cfg.start_min) && (dt <= cfg.start_max);
    assign in_zero  = (dt >= cfg.zero_min) && (dt <= cfg.zero_max);
    assign in_one   = (dt >= cfg.one_min) && (dt <= cfg.one_max);
    assign bit_pos  = FRAME_POS_W'(FRAME_WORD - 1) - FRAME_POS_W'(count_reg);

    always_comb
    begin
        prev_time_next = prev_time_reg;
        armed_next     = armed_reg;
        overflow_next  = overflow_reg;
        count_next     = count_reg;
        frame_next     = frame_reg;
        if (accept)
        begin
            unique case (kind)
                KIND_START:
                begin
                    prev_time_next = '0;
                    armed_next     = 1'b0;
                    overflow_next  = 1'b0;
                    count_next     = '0;
                    frame_next     = '0;
                end
                KIND_EDGE:
                begin
                    prev_time_next = capture_time;
                    if (!armed_reg)
                    begin
                        armed_next = in_start;
                    end
                    else if (in_zero || in_one)
                    begin
                        // zero window wins where the windows overlap
                        if (count_reg == CNT_FULL)
                        begin
                            overflow_next = 1'b1;
                        end
                        else
                        begin
                            frame_next[bit_pos] = !in_zero;
                            count_next          = count_reg + CNT_W'(1);
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_time_reg <= '0;
            armed_reg     <= 1'b0;
            overflow_reg  <= 1'b0;
            count_reg     <= '0;
            frame_reg     <= '0;
        end
        else
        begin
            prev_time_reg <= prev_time_next;
            armed_reg     <= armed_next;
            overflow_reg  <= overflow_next;
            count_reg     <= count_next;
            frame_reg     <= frame_next;
        end
    end

    // Sign-magnitude temperature to two's complement
    assign byte2     = frame_reg[47:40];
    assign magnitude = {1'b0, byte2[6:0], frame_reg[39:32]};

    always_comb
    begin
        result.humidity    = frame_reg[63:48];
        result.temperature = byte2[7] ? $signed(~magnitude + 16'd1) : $signed(magnitude);
        result.checksum    = frame_reg[31:24];
        result.frame_ok    = armed_reg && !overflow_reg && (count_reg == CNT_FULL);
    end

`ifndef ASSERT_OFF
    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("bit count exceeds frame length");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        overflow_reg |-> (count_reg == CNT_FULL))
        else $error("overflow set before frame filled");

    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && kind == KIND_START) |=>
            (count_reg == '0 && !armed_reg && !overflow_reg && frame_reg == '0))
        else $error("start transfer did not clear frame");

    a_bits_need_arm: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) && (count_reg != '0) |-> $past(armed_reg))
        else $error("bit stored while not armed");
`endif

endmodule

@@ rtl/pulse_width_frame_decoder_unit.sv @@
// A finish transfer registers the frame result into the output buffer.
// Throughput: one input transfer per cycle; a two-entry output buffer keeps
// input open while one result waits, and stalls input only when both are full.
// Reset: asynchronous active low; clears the frame, count, flags, previous
// time and output buffer, and loads the default window registers.
module pulse_width_frame_decoder_unit
    import pwfd_pkg::*;
#(
    parameter int FRAME_BITS = FRAME_BITS_DEFAULT
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [KIND_W-1:0]       kind,
    input  logic [TIME_W-1:0]       capture_time,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [15:0]             humidity_tenths,
    output logic signed [15:0]      temperature_tenths,
    output logic [7:0]              checksum_byte,
    output logic                    frame_ok,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [TIME_W-1:0]       cfg_data
);

    pwfd_cfg_t    cfg_reg;
    pwfd_result_t core_result;
    pwfd_result_t front_reg, front_next;
    pwfd_result_t skid_reg, skid_next;
    logic         front_valid_reg, front_valid_next;
    logic         skid_valid_reg, skid_valid_next;
    logic         in_fire, push, pop;

    assign cfg_ready = 1'b1;
    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign push      = in_fire && (kind == KIND_FINISH);
    assign pop       = front_valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_min <= START_MIN_RST;
            cfg_reg.start_max <= START_MAX_RST;
            cfg_reg.zero_min  <= ZERO_MIN_RST;
            cfg_reg.zero_max  <= ZERO_MAX_RST;
            cfg_reg.one_min   <= ONE_MIN_RST;
            cfg_reg.one_max   <= ONE_MAX_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_START_MIN: cfg_reg.start_min <= cfg_data;
                CFG_START_MAX: cfg_reg.start_max <= cfg_data;
                CFG_ZERO_MIN:  cfg_reg.zero_min  <= cfg_data;
                CFG_ZERO_MAX:  cfg_reg.zero_max  <= cfg_data;
                CFG_ONE_MIN:   cfg_reg.one_min   <= cfg_data;
                CFG_ONE_MAX:   cfg_reg.one_max   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    pwfd_frame_core #(
        .FRAME_BITS (FRAME_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (in_fire),
        .kind         (kind),
        .capture_time (capture_time),
        .cfg          (cfg_reg),
        .result       (core_result)
    );

    // Two-entry output buffer: front drives the ports, skid holds the overflow
    always_comb
    begin
        front_next       = front_reg;
        front_valid_next = front_valid_reg;
        skid_next        = skid_reg;
        skid_valid_next  = skid_valid_reg;
        if (!front_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                front_next       = skid_reg;
                front_valid_next = 1'b1;
                skid_valid_next  = 1'b0;
            end
            else
            begin
                front_next       = core_result;
                front_valid_next = push;
            end
        end
        else if (push)
        begin
            skid_next       = core_result;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
            skid_valid_reg  <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
            skid_valid_reg  <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_reg <= front_next;
        skid_reg  <= skid_next;
    end

    assign out_valid          = front_valid_reg;
    assign humidity_tenths    = front_reg.humidity;
    assign temperature_tenths = front_reg.temperature;
    assign checksum_byte      = front_reg.checksum;
    assign frame_ok           = front_reg.frame_ok;

`ifndef ASSERT_OFF
    a_skid_behind_front: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> front_valid_reg)
        else $error("skid entry held with empty front");

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !front_valid_reg) |=> (front_valid_reg && !skid_valid_reg))
        else $error("finish transfer lost from output buffer");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !skid_valid_reg && !push) |=> !front_valid_reg)
        else $error("result repeated after transfer");
`endif

endmodule
